>>> src/assert_macros.svh
// Assertion helpers shared by the RTL.
// ASSERT_PROP: clocked implication, checked outside reset.
// ASSERT_NEVER: clocked check that an expression never holds outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition");
`else
`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)
`endif
`endif

>>> src/qme_pkg.sv
package qme_pkg;

    // Configuration register indexes and reset values
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_DIVIDER       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_INTERVAL = 2'd1;
    localparam logic [7:0]  DIVIDER_RESET       = 8'd2;
    localparam logic [15:0] STEP_INTERVAL_RESET = 16'd300;

    // Item kinds
    localparam logic ACT_MOTION = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // Quadrature phase after reset
    localparam logic [1:0] PHASE_RESET = 2'd1;

    // Divider: 16 dividend bits, two retired per cycle
    localparam int DIV_BITS      = 16;
    localparam int DIV_PER_CYCLE = 2;
    localparam int DIV_CYCLES    = DIV_BITS / DIV_PER_CYCLE;
    localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

    typedef struct packed {
        logic               action;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
    } in_item_t;

    typedef struct packed {
        logic               x_main_level;
        logic               x_quad_level;
        logic               y_main_level;
        logic               y_quad_level;
        logic signed [15:0] x_remaining;
        logic signed [15:0] y_remaining;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic motion;     // add the accepted deltas into the residues
        logic div_load;   // load a residue magnitude into the divider
        logic div_sel_y;  // select the vertical residue for div_load
        logic div_iter;   // retire two quotient bits
        logic div_fin_x;  // commit horizontal quotient and remainder
        logic div_fin_y;  // commit vertical quotient and remainder
        logic step;       // advance quadrature phases and wait counter
        logic out_load;   // capture the result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
    } status_t;

endpackage

>>> src/qme_ctrl.sv
module qme_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  qme_pkg::status_t status,
    output qme_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV_X = 3'd1;
    localparam logic [2:0] ST_FIN_X = 3'd2;
    localparam logic [2:0] ST_DIV_Y = 3'd3;
    localparam logic [2:0] ST_FIN_Y = 3'd4;
    localparam logic [2:0] ST_STEP  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    localparam logic [qme_pkg::DIV_CNT_W-1:0] CNT_LAST =
        qme_pkg::DIV_CNT_W'(qme_pkg::DIV_CYCLES - 1);

    logic [2:0]                      state_reg, state_next;
    logic [qme_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                            m_valid_reg, m_valid_next;
    logic                            out_free;
    logic                            in_take;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_take  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // Ticks: divide, step, capture; motions go straight to capture
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    if (status.is_tick) begin
                        cmd.div_load = 1'b1;
                        cnt_next     = '0;
                        state_next   = ST_DIV_X;
                    end else begin
                        cmd.motion = 1'b1;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIV_X: begin
                cmd.div_iter = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_FIN_X;
                end
            end
            ST_FIN_X: begin
                cmd.div_fin_x = 1'b1;
                cmd.div_load  = 1'b1;
                cmd.div_sel_y = 1'b1;
                cnt_next      = '0;
                state_next    = ST_DIV_Y;
            end
            ST_DIV_Y: begin
                cmd.div_iter = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_FIN_Y;
                end
            end
            ST_FIN_Y: begin
                cmd.div_fin_y = 1'b1;
                state_next    = ST_STEP;
            end
            ST_STEP: begin
                cmd.step   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the result register is free
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid: set on capture, drop once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> src/qme_dp.sv
module qme_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  qme_pkg::in_item_t                   s_data,
    input  logic                                cfg_write,
    input  logic [qme_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [qme_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  qme_pkg::cmd_t                       cmd,
    output qme_pkg::status_t                    status,
    output qme_pkg::out_item_t                  m_data
);

    logic [7:0]         divider_reg;
    logic [15:0]        step_interval_reg;
    logic signed [15:0] x_res_reg, y_res_reg;
    logic signed [15:0] x_pend_reg, y_pend_reg;
    logic [1:0]         x_phase_reg, y_phase_reg;
    logic [15:0]        wait_reg;

    // Shared divider state
    logic [7:0]         rem_reg;
    logic [15:0]        quo_reg;
    logic               neg_reg;

    qme_pkg::out_item_t out_reg;

    logic [7:0]         dvs;
    logic signed [15:0] div_src;
    logic [15:0]        src_mag;
    logic [8:0]         t1, t2;
    logic               ge1, ge2;
    logic [7:0]         r1, r2;
    logic signed [16:0] quo_signed;
    logic signed [15:0] rem_signed;
    logic signed [15:0] pend_sel;
    logic signed [15:0] pend_sum;
    logic signed [15:0] x_mot, y_mot;
    logic               any_pend;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [1:0] phase_step(input logic [1:0] ph,
                                              input logic signed [15:0] pend);
        logic [1:0] r;
        r = ph;
        if (pend > 16'sd0) begin
            r = ph + 2'd1;
        end else if (pend < 16'sd0) begin
            r = ph - 2'd1;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] pend_step(input logic signed [15:0] pend);
        logic signed [15:0] r;
        r = pend;
        if (pend > 16'sd0) begin
            r = pend - 16'sd1;
        end else if (pend < 16'sd0) begin
            r = pend + 16'sd1;
        end
        return r;
    endfunction

    assign status.is_tick = (s_data.action == qme_pkg::ACT_TICK);

    // Zero divider acts as one
    assign dvs = (divider_reg == 8'd0) ? 8'd1 : divider_reg;

    // Magnitude of the residue entering the divider
    assign div_src = cmd.div_sel_y ? y_res_reg : x_res_reg;
    assign src_mag = div_src[15] ? 16'(-div_src) : div_src;

    // Two restoring steps per cycle
    always_comb begin
        t1  = {rem_reg, quo_reg[15]};
        ge1 = (t1 >= {1'b0, dvs});
        r1  = ge1 ? 8'(t1 - {1'b0, dvs}) : t1[7:0];
        t2  = {r1, quo_reg[14]};
        ge2 = (t2 >= {1'b0, dvs});
        r2  = ge2 ? 8'(t2 - {1'b0, dvs}) : t2[7:0];
    end

    // Signed quotient and remainder, truncated toward zero
    assign quo_signed = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign rem_signed = neg_reg ? -$signed({8'd0, rem_reg}) : $signed({8'd0, rem_reg});
    assign pend_sel   = cmd.div_fin_y ? y_pend_reg : x_pend_reg;
    assign pend_sum   = sat16(18'(pend_sel) + 18'(quo_signed));

    assign x_mot = sat16(18'(x_res_reg) + 18'(s_data.dx));
    assign y_mot = sat16(18'(y_res_reg) + 18'(s_data.dy));

    assign any_pend = (x_pend_reg != 16'sd0) || (y_pend_reg != 16'sd0);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divider_reg       <= qme_pkg::DIVIDER_RESET;
            step_interval_reg <= qme_pkg::STEP_INTERVAL_RESET;
        end else if (cfg_write) begin
            if (cfg_index == qme_pkg::REG_DIVIDER) begin
                divider_reg <= cfg_data[7:0];
            end else if (cfg_index == qme_pkg::REG_STEP_INTERVAL) begin
                step_interval_reg <= cfg_data[15:0];
            end
        end
    end

    // Residues, pending counts, phases and wait counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_res_reg   <= '0;
            y_res_reg   <= '0;
            x_pend_reg  <= '0;
            y_pend_reg  <= '0;
            x_phase_reg <= qme_pkg::PHASE_RESET;
            y_phase_reg <= qme_pkg::PHASE_RESET;
            wait_reg    <= '0;
        end else begin
            if (cmd.motion) begin
                x_res_reg <= x_mot;
                y_res_reg <= y_mot;
            end
            if (cmd.div_fin_x) begin
                x_pend_reg <= pend_sum;
                x_res_reg  <= rem_signed;
            end
            if (cmd.div_fin_y) begin
                y_pend_reg <= pend_sum;
                y_res_reg  <= rem_signed;
            end
            if (cmd.step) begin
                if (any_pend && (wait_reg == 16'd0)) begin
                    x_phase_reg <= phase_step(x_phase_reg, x_pend_reg);
                    y_phase_reg <= phase_step(y_phase_reg, y_pend_reg);
                    x_pend_reg  <= pend_step(x_pend_reg);
                    y_pend_reg  <= pend_step(y_pend_reg);
                    wait_reg    <= step_interval_reg;
                end else if (wait_reg != 16'd0) begin
                    wait_reg <= wait_reg - 16'd1;
                end
            end
        end
    end

    // Divider shift registers
    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            rem_reg <= '0;
            quo_reg <= src_mag;
            neg_reg <= div_src[15];
        end else if (cmd.div_iter) begin
            rem_reg <= r2;
            quo_reg <= {quo_reg[13:0], ge1, ge2};
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.x_main_level <= ~x_phase_reg[1];
            out_reg.x_quad_level <= x_phase_reg[1] ^ x_phase_reg[0];
            out_reg.y_main_level <= ~y_phase_reg[1];
            out_reg.y_quad_level <= y_phase_reg[1] ^ y_phase_reg[0];
            out_reg.x_remaining  <= x_pend_reg;
            out_reg.y_remaining  <= y_pend_reg;
        end
    end

    assign m_data = out_reg;

endmodule

>>> src/quadrature_motion_encoder_core.sv
// Quadrature motion encoder core.
// Input channel s_*: motion transactions (action 0) carry signed dx/dy that
// are accumulated into saturating per-axis residues; tick transactions
// (action 1) scale the residues by the divider into pending step counts and
// advance each axis's quadrature phase by at most one step, paced by the
// step interval. Every input transaction yields exactly one result
// transaction on m_*: the four open-drain line levels and the pending counts.
// Configuration port cfg_*: index 0 divider, index 1 step interval; it is
// always ready and is meant to be written while no transaction is in flight.
// Sequence: a motion transaction moves from acceptance to the capture
// state; a tick first runs one shared divider that retires two quotient
// bits per cycle for each axis in turn, then the step state, then capture.
// One transaction is processed at a time; s_ready returns high in the
// cycle after the result is captured, while that result may still wait.
// If the receiver stalls, the finished result holds in the output register
// and the next transaction waits at capture until the register is taken.
// Reset (aresetn low, synchronous) clears residues, counts and wait counter,
// sets both phases to 1, and restores divider 2 and step interval 300.
`include "assert_macros.svh"

module quadrature_motion_encoder_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  qme_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output qme_pkg::out_item_t                  m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [qme_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [qme_pkg::CFG_DATA_W-1:0]      cfg_data
);

    qme_pkg::cmd_t    cmd;
    qme_pkg::status_t status;

    assign cfg_ready = 1'b1;

    qme_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    qme_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_data    (m_data)
    );

    // Never overwrite a result that is still waiting
    `ASSERT_PROP(a_out_free, aclk, aresetn, cmd.out_load |-> (!m_valid || m_ready))
    // No new transaction while a result is being captured or divided
    `ASSERT_NEVER(a_busy_accept, aclk, aresetn, s_ready && (cmd.div_iter || cmd.out_load))
    // Valid rises only from a capture
    `ASSERT_PROP(a_valid_src, aclk, aresetn, $rose(m_valid) |-> $past(cmd.out_load))

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    // Index 3 has no register behind it; writes there must change nothing
    localparam logic [qme_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 30;

    // Tracks encoder state and holds the pin levels and counts each transaction must produce
    class pin_level_scoreboard;
        logic [7:0]          divider;
        logic [15:0]         step_interval;
        logic [15:0]         wait_count;
        logic [1:0]          x_phase;
        logic [1:0]          y_phase;
        int                  x_accum;
        int                  y_accum;
        int                  x_pending;
        int                  y_pending;
        qme_pkg::out_item_t  expected_levels[$];
        int                  error_count;

        function new();
            divider       = qme_pkg::DIVIDER_RESET;
            step_interval = qme_pkg::STEP_INTERVAL_RESET;
            wait_count    = '0;
            x_phase       = qme_pkg::PHASE_RESET;
            y_phase       = qme_pkg::PHASE_RESET;
            x_accum       = 0;
            y_accum       = 0;
            x_pending     = 0;
            y_pending     = 0;
            error_count   = 0;
        endfunction

        function void write_register(logic [qme_pkg::CFG_INDEX_W-1:0] index,
                                     logic [qme_pkg::CFG_DATA_W-1:0] value);
            case (index)
                qme_pkg::REG_DIVIDER: begin
                    divider = value[7:0];
                end
                qme_pkg::REG_STEP_INTERVAL: begin
                    step_interval = value;
                end
                default: begin
                end
            endcase
        endfunction

        function int clamp16(int v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        endfunction

        function void note_item(qme_pkg::in_item_t item);
            int                 d;
            qme_pkg::out_item_t e;
            if (item.action == qme_pkg::ACT_MOTION) begin
                // accumulate deltas into the saturating residues
                x_accum = clamp16(x_accum + int'($signed(item.dx)));
                y_accum = clamp16(y_accum + int'($signed(item.dy)));
            end else begin
                // move whole quotients into the pending counts, keep the remainders
                d = (divider == 8'd0) ? 1 : int'(divider);
                x_pending = clamp16(x_pending + x_accum / d);
                y_pending = clamp16(y_pending + y_accum / d);
                x_accum = x_accum % d;
                y_accum = y_accum % d;
                // step each busy axis once toward zero when the pacing counter is clear
                if ((x_pending != 0 || y_pending != 0) && wait_count == 16'd0) begin
                    if (x_pending > 0) begin
                        x_phase++;
                        x_pending--;
                    end else if (x_pending < 0) begin
                        x_phase--;
                        x_pending++;
                    end
                    if (y_pending > 0) begin
                        y_phase++;
                        y_pending--;
                    end else if (y_pending < 0) begin
                        y_phase--;
                        y_pending++;
                    end
                    wait_count = step_interval;
                end else if (wait_count != 16'd0) begin
                    wait_count--;
                end
            end
            e.x_main_level = (x_phase < 2'd2);
            e.x_quad_level = (x_phase == 2'd1 || x_phase == 2'd2);
            e.y_main_level = (y_phase < 2'd2);
            e.y_quad_level = (y_phase == 2'd1 || y_phase == 2'd2);
            e.x_remaining  = 16'(x_pending);
            e.y_remaining  = 16'(y_pending);
            expected_levels.push_back(e);
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            error_count++;
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got %h expected %h", name, got, want));
        endtask

        task check_levels(qme_pkg::out_item_t got);
            qme_pkg::out_item_t want;
            if (expected_levels.size() == 0) begin
                report("result transaction with nothing outstanding");
                return;
            end
            want = expected_levels.pop_front();
            compare_field("x_main_level", 16'(got.x_main_level), 16'(want.x_main_level));
            compare_field("x_quad_level", 16'(got.x_quad_level), 16'(want.x_quad_level));
            compare_field("y_main_level", 16'(got.y_main_level), 16'(want.y_main_level));
            compare_field("y_quad_level", 16'(got.y_quad_level), 16'(want.y_quad_level));
            compare_field("x_remaining", got.x_remaining, want.x_remaining);
            compare_field("y_remaining", got.y_remaining, want.y_remaining);
        endtask

        function int outstanding();
            return expected_levels.size();
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    qme_pkg::in_item_t               s_data;
    logic                            m_valid;
    logic                            m_ready;
    qme_pkg::out_item_t              m_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [qme_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [qme_pkg::CFG_DATA_W-1:0]  cfg_data;

    pin_level_scoreboard sb = new();
    bit                  idling;
    int                  stall_cycles = 0;

    quadrature_motion_encoder_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Check results and watch for a hang
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_levels(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL quadrature_motion_encoder_core");
                $finish;
            end
        end
    end

    // Result side: stall in random bursts while idling is enabled
    initial begin : result_sink
        int gap;
        gap     = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (gap > 0) begin
                m_ready <= 1'b0;
                gap--;
            end else if (idling && aresetn && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                gap = $urandom_range(0, 9);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Drive one transaction; starts and ends at a falling edge
    task automatic send_item(input qme_pkg::in_item_t item);
        int gap;
        if (idling && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sb.note_item(item);
        @(negedge aclk);
    endtask

    task automatic send_motion(input logic signed [15:0] dx, input logic signed [15:0] dy);
        qme_pkg::in_item_t item;
        item.action = qme_pkg::ACT_MOTION;
        item.dx     = dx;
        item.dy     = dy;
        send_item(item);
    endtask

    // Tick payload deltas are ignored by the block, so fill them with noise
    task automatic send_tick();
        qme_pkg::in_item_t item;
        item.action = qme_pkg::ACT_TICK;
        item.dx     = 16'($urandom);
        item.dy     = 16'($urandom);
        send_item(item);
    endtask

    // Drop valid and hold until every result has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic accept_cfg();
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        sb.write_register(cfg_index, cfg_data);
        @(negedge aclk);
    endtask

    // Write both registers back to back, optionally poking the unused index
    task automatic apply_settings(input logic [15:0] div_word, input logic [15:0] interval,
                                  input bit poke_spare);
        cfg_valid <= 1'b1;
        cfg_index <= qme_pkg::REG_DIVIDER;
        cfg_data  <= div_word;
        accept_cfg();
        cfg_index <= qme_pkg::REG_STEP_INTERVAL;
        cfg_data  <= interval;
        accept_cfg();
        if (poke_spare) begin
            cfg_index <= REG_SPARE;
            cfg_data  <= 16'($urandom);
            accept_cfg();
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly small deltas so counts drain to zero; some full range and extremes
    function automatic logic signed [15:0] pick_delta(int big_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        if (roll < 6 + big_pct)
            return 16'($urandom);
        return 16'($urandom_range(0, 200)) - 16'sd100;
    endfunction

    task automatic run_random(input int count, input int big_pct);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 1) == 1)
                send_tick();
            else
                send_motion(pick_delta(big_pct), pick_delta(big_pct));
        end
    endtask

    initial begin : stimulus
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idling    = 1'b1;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: residues saturate, ticks leave only remainders
        send_motion(16'sd1, -16'sd1);
        send_tick();
        send_motion(16'sh7FFF, 16'sh8000);
        send_motion(16'sh7FFF, 16'sh8000);
        send_motion(16'sh8000, 16'sh7FFF);
        send_tick();
        wait_idle();

        // Divider zero and step interval zero: step on every tick
        apply_settings(16'd0, 16'd0, 1'b1);
        send_tick();
        send_motion(16'sh7FFF, 16'sh7FFF);
        send_motion(16'sh7FFF, -16'sd1);
        send_tick();
        send_motion(16'sh7FFF, 16'sh7FFF);
        send_tick();
        send_motion(16'sh8000, 16'sh8000);
        send_motion(16'sh8000, 16'sh8000);
        send_motion(16'sh8000, 16'sh8000);
        send_tick();
        send_tick();
        send_tick();
        send_tick();
        send_motion(-16'sd5, 16'sd7);
        send_tick();

        // Random phases over several settings
        run_random(280, 20);
        wait_idle();

        apply_settings(16'd1, 16'd1, 1'b0);
        run_random(260, 30);
        wait_idle();

        idling = 1'b0;
        apply_settings({8'($urandom), 8'($urandom_range(2, 254))},
                       16'($urandom_range(2, 9)), 1'b0);
        run_random(200, 25);
        wait_idle();

        idling = 1'b1;
        apply_settings(16'd3, 16'd0, 1'b0);
        run_random(200, 15);
        wait_idle();

        // Last part without idling: widest divider and longest interval
        idling = 1'b0;
        apply_settings({8'($urandom), 8'd255}, 16'hFFFF, 1'b1);
        run_random(180, 40);
        wait_idle();

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (sb.error_count == 0)
            $display("PASS quadrature_motion_encoder_core");
        else
            $display("FAIL quadrature_motion_encoder_core");
        $finish;
    end

endmodule
